// File: rtl/core/modular_exponentiation_defines.svh
// assertion macros for the modular exponentiation core
// used by the top level only; no other dependencies
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mexp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mexp assertion failed");

`endif

// File: rtl/core/mexp_pkg.sv
// shared constants and controller/datapath interface types
// no dependencies
`default_nettype none

package mexp_pkg;

    // operand width of base, modulus and result
    localparam int VAL_W = 31;
    // exponent port width
    localparam int EXP_W = 32;
    // number of exponent bits that take part
    localparam int EXP_BITS = 32;
    localparam int EXP_N = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam logic [EXP_W-1:0] EXP_MASK = {EXP_W{1'b1}} >> (EXP_W - EXP_N);

    // step counter of the serial multiply-reduce unit
    localparam int CNT_W = $clog2(VAL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VAL_W - 1);

    typedef struct packed {
        logic load;          // capture a new request
        logic clr_acc;       // force the accumulator to zero
        logic start_reduce;  // square reg <= square reg mod m
        logic start_mul;     // acc <= acc * square mod m
        logic start_sqr;     // square <= square * square mod m
        logic shift_exp;     // move to the next exponent bit
        logic out_load;      // copy accumulator to the output register
    } mexp_cmd_t;

    typedef struct packed {
        logic mm_busy;       // multiply-reduce unit running
        logic mm_done;       // one-cycle pulse after a product is written
        logic exp_bit;       // current exponent bit
        logic exp_rest_zero; // no set bit above the current one
        logic exp_zero;      // remaining exponent is zero
        logic mod_zero;      // modulus is zero
    } mexp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/modular_exponentiation.sv
// run time from request to result grows with the top set exponent bit index k and
// the set bit count s; a zero exponent or zero modulus skips the products, and a
// result still waiting stalls the output of the next one
// throughput: one request at a time, set by the shared serial multiply-reduce unit
// (31 steps per modular product); the next request is taken while a result waits
// reset: synchronous active-low aresetn clears the controller and output valid
`default_nettype none
`include "modular_exponentiation_defines.svh"

// top level: right-to-left square-and-multiply modular exponentiation
// depends on mexp_pkg, mexp_datapath, mexp_ctrl
module modular_exponentiation (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // request channel
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [mexp_pkg::VAL_W-1:0] s_base,
    input  wire logic [mexp_pkg::EXP_W-1:0] s_exponent,
    input  wire logic [mexp_pkg::VAL_W-1:0] s_modulus,
    // result channel
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [mexp_pkg::VAL_W-1:0]      m_power
);

    // command and status between the sequencer and the datapath
    mexp_pkg::mexp_cmd_t cmd;
    mexp_pkg::mexp_sts_t sts;

    // datapath: modulus, exponent shifter, square and accumulator registers,
    // and the bit-serial (2r + bit*a) mod m unit shared by every product
    mexp_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .s_modulus  (s_modulus),
        .cmd        (cmd),
        .sts        (sts),
        .m_power    (m_power)
    );

    // controller: reduces the base first, then per exponent bit a conditional
    // multiply and a square, stopping once no set bit remains
    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // a request accepted leaves the block busy for at least the next cycle
    `MEXP_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // the shared unit is never restarted while it is still running
    `MEXP_ASSERT_NOW(a_no_restart, aclk, aresetn,
        cmd.start_reduce || cmd.start_mul || cmd.start_sqr, !sts.mm_busy)
    // at most one product started per cycle
    `MEXP_ASSERT_NOW(a_one_start, aclk, aresetn, 1'b1,
        $onehot0({cmd.start_reduce, cmd.start_mul, cmd.start_sqr}))

endmodule

`default_nettype wire

// File: rtl/core/mexp_datapath.sv
// datapath: operand registers, serial multiply-reduce unit, output register
// depends on mexp_pkg
`default_nettype none

module mexp_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [mexp_pkg::VAL_W-1:0] s_base,
    input  wire logic [mexp_pkg::EXP_W-1:0] s_exponent,
    input  wire logic [mexp_pkg::VAL_W-1:0] s_modulus,
    input  wire mexp_pkg::mexp_cmd_t       cmd,
    output mexp_pkg::mexp_sts_t            sts,
    output logic [mexp_pkg::VAL_W-1:0]     m_power
);

    logic [mexp_pkg::VAL_W-1:0] mod_reg;
    logic [mexp_pkg::EXP_W-1:0] exp_reg;
    logic [mexp_pkg::VAL_W-1:0] sq_reg;
    logic [mexp_pkg::VAL_W-1:0] acc_reg;
    logic [mexp_pkg::VAL_W-1:0] mcand_reg;
    logic [mexp_pkg::VAL_W-1:0] mplier_reg;
    logic [mexp_pkg::VAL_W-1:0] r_reg;
    logic [mexp_pkg::CNT_W-1:0] cnt_reg;
    logic                       dst_acc_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [mexp_pkg::VAL_W-1:0] power_reg;

    logic [mexp_pkg::VAL_W:0]   dbl;
    logic [mexp_pkg::VAL_W:0]   dbl_red;
    logic [mexp_pkg::VAL_W:0]   sum;
    logic [mexp_pkg::VAL_W:0]   sum_red;
    logic [mexp_pkg::VAL_W-1:0] addend;
    logic [mexp_pkg::VAL_W-1:0] r_next;
    logic                       last_step;

    // one step of msb-first interleaved multiply: r = (2r + bit*a) mod m
    always_comb begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, mod_reg}) ? dbl - {1'b0, mod_reg} : dbl;
        addend  = mplier_reg[mexp_pkg::VAL_W-1] ? mcand_reg : '0;
        sum     = {1'b0, dbl_red[mexp_pkg::VAL_W-1:0]} + {1'b0, addend};
        sum_red = (sum >= {1'b0, mod_reg}) ? sum - {1'b0, mod_reg} : sum;
        r_next  = sum_red[mexp_pkg::VAL_W-1:0];
    end

    assign last_step = busy_reg && (cnt_reg == mexp_pkg::CNT_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= last_step;
            if (cmd.start_reduce || cmd.start_mul || cmd.start_sqr) begin
                busy_reg <= 1'b1;
            end else if (last_step) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mod_reg <= s_modulus;
            exp_reg <= s_exponent & mexp_pkg::EXP_MASK;
            sq_reg  <= s_base;
            acc_reg <= mexp_pkg::VAL_W'(1);
        end
        if (cmd.clr_acc) begin
            acc_reg <= '0;
        end
        if (cmd.shift_exp) begin
            exp_reg <= exp_reg >> 1;
        end
        if (cmd.start_reduce) begin
            mcand_reg   <= mexp_pkg::VAL_W'(1);
            mplier_reg  <= sq_reg;
            dst_acc_reg <= 1'b0;
        end
        if (cmd.start_mul) begin
            mcand_reg   <= sq_reg;
            mplier_reg  <= acc_reg;
            dst_acc_reg <= 1'b1;
        end
        if (cmd.start_sqr) begin
            mcand_reg   <= sq_reg;
            mplier_reg  <= sq_reg;
            dst_acc_reg <= 1'b0;
        end
        if (cmd.start_reduce || cmd.start_mul || cmd.start_sqr) begin
            r_reg   <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            r_reg      <= r_next;
            mplier_reg <= mplier_reg << 1;
            cnt_reg    <= cnt_reg + mexp_pkg::CNT_W'(1);
        end
        if (last_step) begin
            if (dst_acc_reg) begin
                acc_reg <= r_next;
            end else begin
                sq_reg <= r_next;
            end
        end
        if (cmd.out_load) begin
            power_reg <= acc_reg;
        end
    end

    always_comb begin
        sts.mm_busy       = busy_reg;
        sts.mm_done       = done_reg;
        sts.exp_bit       = exp_reg[0];
        sts.exp_rest_zero = (exp_reg[mexp_pkg::EXP_W-1:1] == '0);
        sts.exp_zero      = (exp_reg == '0);
        sts.mod_zero      = (mod_reg == '0);
    end

    assign m_power = power_reg;

endmodule

`default_nettype wire

// File: rtl/core/mexp_ctrl.sv
// controller: sequences reduce, multiply and square steps over exponent bits
// depends on mexp_pkg
`default_nettype none

module mexp_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire mexp_pkg::mexp_sts_t sts,
    output mexp_pkg::mexp_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_REDUCE = 3'd2;
    localparam logic [2:0] ST_BIT    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_SQR    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.exp_zero) begin
                    state_next = ST_FINISH;
                end else if (sts.mod_zero) begin
                    cmd.clr_acc = 1'b1;
                    state_next  = ST_FINISH;
                end else begin
                    cmd.start_reduce = 1'b1;
                    state_next       = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (sts.mm_done) begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                if (sts.exp_bit) begin
                    cmd.start_mul = 1'b1;
                    state_next    = ST_MUL;
                end else if (sts.exp_rest_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.start_sqr = 1'b1;
                    state_next    = ST_SQR;
                end
            end
            ST_MUL: begin
                if (sts.mm_done) begin
                    if (sts.exp_rest_zero) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.start_sqr = 1'b1;
                        state_next    = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (sts.mm_done) begin
                    cmd.shift_exp = 1'b1;
                    state_next    = ST_BIT;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
